// ===== design/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// Types and constants shared by the selective-repeat sender window block.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_OFFER  = 2'd1;
  localparam logic [1:0] OP_ACK    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_SENT     = 3'd0;
  localparam logic [2:0] KIND_RETX     = 3'd1;
  localparam logic [2:0] KIND_ACKED    = 3'd2;
  localparam logic [2:0] KIND_IGNORED  = 3'd3;
  localparam logic [2:0] KIND_FULL     = 3'd4;
  localparam logic [2:0] KIND_REFUSED  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_SEQ_BITS  = 3'd0;
  localparam logic [2:0] CFG_WINDOW    = 3'd1;
  localparam logic [2:0] CFG_ACK_TGT   = 3'd2;
  localparam logic [2:0] CFG_INIT_TO   = 3'd3;
  localparam logic [2:0] CFG_TO_MULT   = 3'd4;
  localparam logic [2:0] CFG_RETRY_LIM = 3'd5;
  localparam logic [2:0] CFG_WARMUP    = 3'd6;

  localparam int CFG_DATA_W  = 32;
  localparam int RTT_TOTAL_W = 52;
  localparam int MULT_W      = 8;
  localparam int MULT_RTT_W  = MULT_W + RTT_TOTAL_W;
  localparam int RETRY_W     = 4;
  localparam logic [RETRY_W-1:0] RETRY_MAX = 4'd15;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] ack_sequence;
  } srsw_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [5:0]  out_sequence;
    logic [31:0] rtt_sample;
    logic        halted;
    logic        last;
  } srsw_result_t;

endpackage

`default_nettype wire

// ===== design/srsw_expiry_unit.sv =====
// ----------------------------------------------------------------------------
// srsw_expiry_unit
// Shared timeout test: registered elapsed x acks product, then compare.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_expiry_unit
  import srsw_pkg::*;
#(
  parameter int TIME_BITS      = 32,
  parameter int ACK_COUNT_BITS = 20
) (
  input  wire logic                      clk,
  input  wire logic [TIME_BITS-1:0]      elapsed,
  input  wire logic [ACK_COUNT_BITS-1:0] acked,
  input  wire logic                      warm,
  input  wire logic [31:0]               init_timeout,
  input  wire logic [MULT_RTT_W-1:0]     mult_rtt,
  output logic                           expired
);

  localparam int PW   = TIME_BITS + ACK_COUNT_BITS;
  localparam int CMPW = (PW > MULT_RTT_W) ? PW : MULT_RTT_W;
  localparam int TW   = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [PW-1:0]        prod;
  logic [TIME_BITS-1:0] elapsed_q;
  logic                 warm_q;

  always_ff @(posedge clk) begin
    prod      <= PW'(elapsed) * PW'(acked);
    elapsed_q <= elapsed;
    warm_q    <= warm;
  end

  assign expired = warm_q ? (CMPW'(prod) >= CMPW'(mult_rtt))
                          : (TW'(elapsed_q) >= TW'(init_timeout));

endmodule

`default_nettype wire

// ===== design/selective_repeat_sender_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Selective-repeat sender bookkeeping: sends, acks and timer scans.
// ----------------------------------------------------------------------------
// offer, ignored ack, unused op, halted refusal: handled in S_IDLE, any result next cycle
// accepted ack: S_IDLE, then S_ACK (one read of the send-time memory)
// tick: S_RD, S_EVAL and S_UPD for each entry through the shared expiry unit,
// then S_EMIT and S_FLUSH emit retransmits; stalled results hold the walk
// rst is synchronous: it clears the state, flags and counters and loads the configuration defaults;
// the timer memories are not cleared and need no clearing pass
`default_nettype none

module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int SEQ_SPACE      = 64,
  parameter int TIME_BITS      = 32,
  parameter int ACK_COUNT_BITS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire srsw_item_t            item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output srsw_result_t               result,
  input  wire logic                  cfg_write,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(SEQ_SPACE);
  localparam int SW    = IDX_W + 1;
  localparam int OCW   = $clog2(SEQ_SPACE + 1);
  localparam int CW    = (SW > 7) ? SW : 7;
  localparam int TGW   = (ACK_COUNT_BITS > 20) ? ACK_COUNT_BITS : 20;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQ_SPACE - 1);
  localparam logic [ACK_COUNT_BITS-1:0] ACK_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_ACK, S_RD, S_EVAL, S_UPD, S_EMIT, S_FLUSH
  } state_t;

  // configuration
  logic [2:0]  seq_width;
  logic [6:0]  window_limit;
  logic [19:0] ack_target;
  logic [31:0] init_timeout;
  logic [7:0]  rtt_factor;
  logic [3:0]  retry_limit;
  logic [7:0]  warmup_acks;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_width    <= 3'd6;
      window_limit <= 7'd8;
      ack_target   <= 20'd400;
      init_timeout <= 32'd300000;
      rtt_factor   <= 8'd12;
      retry_limit  <= 4'd10;
      warmup_acks  <= 8'd10;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEQ_BITS:  seq_width    <= cfg_data[2:0];
        CFG_WINDOW:    window_limit <= cfg_data[6:0];
        CFG_ACK_TGT:   ack_target   <= cfg_data[19:0];
        CFG_INIT_TO:   init_timeout <= cfg_data[31:0];
        CFG_TO_MULT:   rtt_factor   <= cfg_data[7:0];
        CFG_RETRY_LIM: retry_limit  <= cfg_data[3:0];
        CFG_WARMUP:    warmup_acks  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // state
  state_t                    state;
  logic [IDX_W-1:0]          idx;
  logic [SEQ_SPACE-1:0]      exp_vec;
  logic                      halt_acc;
  logic                      pend_v;
  logic [IDX_W-1:0]          pend_idx;
  logic [IDX_W-1:0]          ack_idx_q;
  logic [SEQ_SPACE-1:0]      outstanding;
  logic [SEQ_SPACE-1:0]      rc_valid;
  logic [IDX_W-1:0]          next_seq;
  logic [OCW-1:0]            out_cnt;
  logic [ACK_COUNT_BITS-1:0] acked;
  logic [RTT_TOTAL_W-1:0]    rtt_total;
  logic [TIME_BITS-1:0]      now;
  logic                      halt_flag;
  logic [MULT_RTT_W-1:0]     mult_rtt;

  // memories
  logic [TIME_BITS-1:0] first_time [SEQ_SPACE];
  logic [TIME_BITS-1:0] last_time  [SEQ_SPACE];
  logic [RETRY_W-1:0]   retry_mem  [SEQ_SPACE];
  logic [TIME_BITS-1:0] ft_rd;
  logic [TIME_BITS-1:0] lt_rd;
  logic [RETRY_W-1:0]   rc_rd;
  logic                 rc_v_rd;

  // derived values
  logic [8:0]       sp_raw;
  logic [SW-1:0]    space;
  logic [IDX_W-1:0] seq_mask;
  logic [8:0]       win;
  logic [IDX_W-1:0] offer_idx;
  logic             full;
  logic [CW-1:0]    ack_ext;
  logic [IDX_W-1:0] ack_idx;
  logic             ack_ok;
  logic             warm;
  logic             out_free;
  logic             accept;
  logic             offer_go;

  logic [TIME_BITS-1:0]      rtt;
  logic [RTT_TOTAL_W:0]      rtt_sum;
  logic [RTT_TOTAL_W-1:0]    rtt_new;
  logic [ACK_COUNT_BITS-1:0] acked_new;
  logic                      halt_new;

  logic               exp_ok;
  logic               hit;
  logic [RETRY_W-1:0] rc_cur;
  logic [RETRY_W-1:0] rc_inc;
  logic [RETRY_W-1:0] rc_new;
  logic               over;
  logic               emit_block;

  logic               ld;
  srsw_result_t       ld_d;
  logic               lt_we;
  logic [IDX_W-1:0]   lt_wa;
  logic [IDX_W-1:0]   ft_ra;

  always_comb begin
    sp_raw   = 9'd1 << ((seq_width == 3'd0) ? 3'd1 : seq_width);
    space    = (sp_raw > 9'(SEQ_SPACE)) ? SW'(SEQ_SPACE) : SW'(sp_raw);
    seq_mask = IDX_W'(space - SW'(1));
    win      = ({2'b00, window_limit} > 9'(space)) ? 9'(space) : {2'b00, window_limit};
    offer_idx = next_seq & seq_mask;
    full     = (9'(out_cnt) >= win) || outstanding[offer_idx];
    ack_ext  = CW'(item.ack_sequence);
    ack_idx  = ack_ext[IDX_W-1:0];
    ack_ok   = (ack_ext < CW'(space)) && outstanding[ack_idx];
    warm     = acked > ACK_COUNT_BITS'(warmup_acks);
    out_free = !result_valid || !result_stall;
    item_stall = !((state == S_IDLE) && out_free);
    accept   = item_valid && !item_stall;
    offer_go = accept && !halt_flag && (item.op == OP_OFFER) && !full;

    rtt       = now - ft_rd;
    rtt_sum   = {1'b0, rtt_total} + (RTT_TOTAL_W+1)'(rtt);
    rtt_new   = rtt_sum[RTT_TOTAL_W] ? '1 : rtt_sum[RTT_TOTAL_W-1:0];
    acked_new = (acked == ACK_MAX) ? acked : acked + ACK_COUNT_BITS'(1);
    halt_new  = TGW'(acked_new) >= TGW'(ack_target);

    hit    = exp_ok && outstanding[idx] && ({1'b0, idx} < space);
    rc_cur = rc_v_rd ? rc_rd : '0;
    rc_inc = (rc_cur == RETRY_MAX) ? rc_cur : rc_cur + RETRY_W'(1);
    rc_new = hit ? rc_inc : rc_cur;
    over   = rc_new > retry_limit;
    emit_block = exp_vec[idx] && pend_v && !out_free;

    lt_we = offer_go || ((state == S_UPD) && hit);
    lt_wa = (state == S_IDLE) ? offer_idx : idx;
    ft_ra = (state == S_IDLE) ? ack_idx : ack_idx_q;

    ld   = 1'b0;
    ld_d = '0;
    case (state)
      S_IDLE: begin
        if (accept && (item.op != OP_UNUSED)) begin
          if (halt_flag) begin
            ld = 1'b1;
            ld_d.result_kind = KIND_REFUSED;
            ld_d.halted = 1'b1;
            ld_d.last = 1'b1;
          end else if (item.op == OP_OFFER) begin
            ld = 1'b1;
            ld_d.result_kind = full ? KIND_FULL : KIND_SENT;
            ld_d.out_sequence = full ? 6'd0 : 6'(offer_idx);
            ld_d.last = 1'b1;
          end else if ((item.op == OP_ACK) && !ack_ok) begin
            ld = 1'b1;
            ld_d.result_kind = KIND_IGNORED;
            ld_d.out_sequence = item.ack_sequence;
            ld_d.last = 1'b1;
          end
        end
      end
      S_ACK: begin
        if (out_free) begin
          ld = 1'b1;
          ld_d.result_kind = KIND_ACKED;
          ld_d.out_sequence = 6'(ack_idx_q);
          ld_d.rtt_sample = 32'(rtt);
          ld_d.halted = halt_new;
          ld_d.last = 1'b1;
        end
      end
      S_EMIT: begin
        if (exp_vec[idx] && pend_v && out_free) begin
          ld = 1'b1;
          ld_d.result_kind = KIND_RETX;
          ld_d.out_sequence = 6'(pend_idx);
          ld_d.halted = halt_flag;
        end
      end
      S_FLUSH: begin
        if (pend_v && out_free) begin
          ld = 1'b1;
          ld_d.result_kind = KIND_RETX;
          ld_d.out_sequence = 6'(pend_idx);
          ld_d.halted = halt_flag;
          ld_d.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lt_we) last_time[lt_wa] <= now;
    if (offer_go) first_time[offer_idx] <= now;
    if ((state == S_UPD) && hit) retry_mem[idx] <= rc_inc;
    lt_rd <= last_time[idx];
    rc_rd <= retry_mem[idx];
    ft_rd <= first_time[ft_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) rc_v_rd <= 1'b0;
    else     rc_v_rd <= rc_valid[idx];
  end

  srsw_expiry_unit #(
    .TIME_BITS      (TIME_BITS),
    .ACK_COUNT_BITS (ACK_COUNT_BITS)
  ) u_expiry (
    .clk          (clk),
    .elapsed      (now - lt_rd),
    .acked        (acked),
    .warm         (warm),
    .init_timeout (init_timeout),
    .mult_rtt     (mult_rtt),
    .expired      (exp_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      outstanding  <= '0;
      rc_valid     <= '0;
      next_seq     <= '0;
      out_cnt      <= '0;
      acked        <= '0;
      rtt_total    <= '0;
      now          <= '0;
      halt_flag    <= 1'b0;
      pend_v       <= 1'b0;
      idx          <= '0;
    end else begin
      if (ld) begin
        result_valid <= 1'b1;
        result       <= ld_d;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && !halt_flag) begin
            case (item.op)
              OP_TICK: begin
                now      <= now + TIME_BITS'(1);
                idx      <= '0;
                exp_vec  <= '0;
                halt_acc <= 1'b0;
                mult_rtt <= MULT_RTT_W'(rtt_factor) * MULT_RTT_W'(rtt_total);
                state    <= S_RD;
              end
              OP_OFFER: begin
                if (!full) begin
                  outstanding[offer_idx] <= 1'b1;
                  out_cnt  <= out_cnt + OCW'(1);
                  next_seq <= (offer_idx + IDX_W'(1)) & seq_mask;
                end
              end
              OP_ACK: begin
                if (ack_ok) begin
                  ack_idx_q <= ack_idx;
                  state     <= S_ACK;
                end
              end
              default: ;
            endcase
          end
        end
        S_ACK: begin
          if (out_free) begin
            outstanding[ack_idx_q] <= 1'b0;
            if (out_cnt != '0) out_cnt <= out_cnt - OCW'(1);
            rtt_total <= rtt_new;
            acked     <= acked_new;
            if (halt_new) halt_flag <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RD:   state <= S_EVAL;
        S_EVAL: state <= S_UPD;
        S_UPD: begin
          if (hit) begin
            rc_valid[idx] <= 1'b1;
            exp_vec[idx]  <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            halt_flag <= halt_acc | over;
            idx       <= '0;
            pend_v    <= 1'b0;
            state     <= S_EMIT;
          end else begin
            halt_acc <= halt_acc | over;
            idx      <= idx + IDX_W'(1);
            state    <= S_RD;
          end
        end
        S_EMIT: begin
          if (!emit_block) begin
            if (exp_vec[idx]) begin
              pend_v   <= 1'b1;
              pend_idx <= idx;
            end
            if (idx == LAST_IDX) state <= S_FLUSH;
            else idx <= idx + IDX_W'(1);
          end
        end
        S_FLUSH: begin
          if (!pend_v) begin
            idx   <= '0;
            state <= S_IDLE;
          end else if (out_free) begin
            pend_v <= 1'b0;
            idx    <= '0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
